// ----- rtl/core/pnmd_pkg.sv -----
// Shared types and command codes of the PNM stream decoder.
// No dependencies; the datapath, the controller and the top level import this package.
package pnmd_pkg;

    localparam int MAX_SIDE_DEF = 16384;

    // Commands from the controller to the datapath.
    typedef logic [3:0] t_cmd;
    localparam t_cmd CMD_NONE      = 4'd0;
    localparam t_cmd CMD_LOAD      = 4'd1;
    localparam t_cmd CMD_DIV_START = 4'd2;
    localparam t_cmd CMD_DIV_STEP  = 4'd3;
    localparam t_cmd CMD_EXEC      = 4'd4;
    localparam t_cmd CMD_BIT       = 4'd5;
    localparam t_cmd CMD_STAT      = 4'd6;
    localparam t_cmd CMD_EDELIV    = 4'd7;
    localparam t_cmd CMD_ERESET    = 4'd8;
    localparam t_cmd CMD_FLUSH     = 4'd9;

    typedef struct packed {
        logic need_div_byte;
        logic need_div_eof;
        logic div_last;
        logic bits_nz;
        logic stat_pend;
        logic eof;
        logic slot_free;
    } t_dp_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [14:0] width;
        logic [14:0] height;
        logic [1:0]  chans;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [2:0]  code;
        logic        last;
    } t_result;

endpackage

// ----- rtl/core/pnmd_in_if.sv -----
// Byte input channel of the PNM stream decoder.
// Stand-alone valid/ready interface; no dependencies.
interface pnmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ----- rtl/core/pnmd_out_if.sv -----
// Result output channel of the PNM stream decoder.
// Stand-alone valid/ready interface; no dependencies.
interface pnmd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic [1:0]  channels;
    logic [7:0]  gray_or_red;
    logic [7:0]  green_value;
    logic [7:0]  blue_value;
    logic [2:0]  status_code;
    logic        last_of_run;

    modport source (output valid, output result_kind, output image_width,
                    output image_height, output channels, output gray_or_red,
                    output green_value, output blue_value, output status_code,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input image_width,
                    input image_height, input channels, input gray_or_red,
                    input green_value, input blue_value, input status_code,
                    input last_of_run, output ready);
endinterface

// ----- rtl/core/pnmd_datapath.sv -----
// Datapath of the PNM stream decoder: parser state, header checks, range divider,
// pixel counters and the two-entry result queue. Depends on pnmd_pkg.
module pnmd_datapath import pnmd_pkg::*; #(
    parameter int P_MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_byte,
    input  logic        i_eof,
    input  logic        i_out_ready,
    output t_dp_status  o_status,
    output t_result     o_result,
    output logic        o_result_valid
);

    localparam logic [3:0] PH_MAGIC_P     = 4'd0;
    localparam logic [3:0] PH_MAGIC_TYPE  = 4'd1;
    localparam logic [3:0] PH_MAGIC_SPACE = 4'd2;
    localparam logic [3:0] PH_EXTRA       = 4'd3;
    localparam logic [3:0] PH_WIDTH       = 4'd4;
    localparam logic [3:0] PH_HEIGHT      = 4'd5;
    localparam logic [3:0] PH_RANGE       = 4'd6;
    localparam logic [3:0] PH_ASCII       = 4'd7;
    localparam logic [3:0] PH_BINARY      = 4'd8;
    localparam logic [3:0] PH_DONE        = 4'd9;

    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_PIX  = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_MAGIC = 3'd1;
    localparam logic [2:0] ST_SIZE  = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;

    localparam logic [30:0] ACC_LIMIT = 31'd214748363;
    localparam logic [30:0] RANGE_16B = 31'd257;
    localparam logic [30:0] RANGE_MAX = 31'd255;
    localparam logic [30:0] SIDE_MAX  = 31'(P_MAX_SIDE);

    function automatic logic [7:0] scale7(input logic [2:0] x);
        logic [7:0] r;
        case (x)
            3'd0:    r = 8'd0;
            3'd1:    r = 8'd36;
            3'd2:    r = 8'd72;
            3'd3:    r = 8'd109;
            3'd4:    r = 8'd145;
            3'd5:    r = 8'd182;
            3'd6:    r = 8'd218;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] scale3(input logic [1:0] x);
        logic [7:0] r;
        case (x)
            2'd0:    r = 8'd0;
            2'd1:    r = 8'd85;
            2'd2:    r = 8'd170;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] fail_code(input logic [3:0] ph);
        logic [2:0] c;
        if (ph <= PH_MAGIC_SPACE)  c = ST_MAGIC;
        else if (ph <= PH_HEIGHT)  c = ST_SIZE;
        else if (ph == PH_RANGE)   c = ST_RANGE;
        else                       c = ST_DATA;
        return c;
    endfunction

    function automatic t_result mk_res(input logic [1:0] kind, input logic [14:0] w,
                                       input logic [14:0] h, input logic [1:0] ch,
                                       input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic [2:0] code);
        t_result x;
        x.kind   = kind;
        x.width  = w;
        x.height = h;
        x.chans  = ch;
        x.red    = r;
        x.green  = g;
        x.blue   = b;
        x.code   = code;
        x.last   = 1'b0;
        return x;
    endfunction

    // Parser state.
    logic [7:0]  r_byte, n_byte;
    logic        r_eof, n_eof;
    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_ft, n_ft;
    logic [30:0] r_acc, n_acc;
    logic        r_na, n_na;
    logic        r_cmt, n_cmt;
    logic [14:0] r_w, n_w, r_h, n_h;
    logic [7:0]  r_rng, n_rng;
    logic [14:0] r_col, n_col, r_row, n_row;
    logic [1:0]  r_ci, n_ci;
    logic [7:0]  r_hr, n_hr, r_hg, n_hg;
    // Range divider.
    logic [8:0]  r_rem, n_rem;
    logic [7:0]  r_lo, n_lo;
    logic [7:0]  r_q, n_q;
    logic [2:0]  r_dcnt, n_dcnt;
    // Bitmap byte unpacking.
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_bsh, n_bsh;
    // Pending status and result queue.
    logic        r_sp, n_sp;
    logic [2:0]  r_scode, n_scode;
    t_result     r_pend, n_pend, r_out, n_out;
    logic        r_pend_v, n_pend_v, r_out_v, n_out_v;

    logic        dig, spc;
    logic [1:0]  chan;
    logic [15:0] col_inc, row_inc;
    logic        px_wrap, px_done;
    logic [14:0] px_col, px_row;
    logic        side_ok, rng_ok;
    logic [7:0]  rng_v;
    logic [33:0] acc_x10;
    logic [7:0]  div_v, div_vc;
    logic [15:0] dvd;
    logic [8:0]  div_t;
    logic [14:0] bits_rem;

    assign dig  = (r_byte >= 8'd48) && (r_byte <= 8'd57);
    assign spc  = (r_byte == 8'd32) || ((r_byte >= 8'd9) && (r_byte <= 8'd13));
    assign chan = ((r_ft == 3'd3) || (r_ft == 3'd6) || (r_ft == 3'd7)) ? 2'd3 : 2'd1;

    assign col_inc = {1'b0, r_col} + 16'd1;
    assign row_inc = {1'b0, r_row} + 16'd1;
    assign px_wrap = col_inc >= {1'b0, r_w};
    assign px_done = px_wrap && (row_inc >= {1'b0, r_h});
    assign px_col  = px_wrap ? 15'd0 : col_inc[14:0];
    assign px_row  = px_wrap ? row_inc[14:0] : r_row;

    assign side_ok = (r_acc != 31'd0) && (r_acc <= SIDE_MAX);
    assign rng_ok  = (r_acc == RANGE_16B) || ((r_acc != 31'd0) && (r_acc <= RANGE_MAX));
    assign rng_v   = (r_acc == RANGE_16B) ? 8'd255 : r_acc[7:0];
    assign acc_x10 = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0};

    assign div_v  = (r_phase == PH_BINARY) ? r_byte : r_acc[7:0];
    assign div_vc = (div_v > r_rng) ? r_rng : div_v;
    assign dvd    = {div_vc, 8'h00} - {8'h00, div_vc};
    assign div_t  = {r_rem[7:0], r_lo[7]};
    assign bits_rem = r_w - r_col;

    // Hand-over of a finished header or data integer.
    logic [3:0]  d_phase;
    logic [14:0] d_w, d_h, d_col, d_row;
    logic [7:0]  d_rng, d_hr, d_hg;
    logic [1:0]  d_ci;
    logic        d_gen, d_stat, d_consumed;
    logic [2:0]  d_code;
    t_result     d_res;

    always_comb begin
        d_phase = r_phase;
        d_w = r_w;
        d_h = r_h;
        d_rng = r_rng;
        d_col = r_col;
        d_row = r_row;
        d_ci = r_ci;
        d_hr = r_hr;
        d_hg = r_hg;
        d_gen = 1'b0;
        d_stat = 1'b0;
        d_code = ST_OK;
        d_consumed = 1'b1;
        d_res = mk_res(KIND_PIX, 15'd0, 15'd0, chan, 8'd0, 8'd0, 8'd0, ST_OK);
        case (r_phase)
            PH_EXTRA: begin
                d_phase = PH_WIDTH;
                d_consumed = 1'b0;
            end
            PH_WIDTH: begin
                if (side_ok) begin
                    d_w = r_acc[14:0];
                    d_phase = PH_HEIGHT;
                    d_consumed = 1'b0;
                end else begin
                    d_stat = 1'b1;
                    d_code = ST_SIZE;
                    d_phase = PH_DONE;
                end
            end
            PH_HEIGHT: begin
                if (side_ok) begin
                    d_h = r_acc[14:0];
                    d_gen = 1'b1;
                    d_res = mk_res(KIND_HDR, r_w, r_acc[14:0], chan, 8'd0, 8'd0, 8'd0, ST_OK);
                    if ((r_ft == 3'd1) || (r_ft == 3'd4)) begin
                        d_rng = 8'd1;
                        d_col = 15'd0;
                        d_row = 15'd0;
                        d_ci = 2'd0;
                        d_phase = (r_ft <= 3'd3) ? PH_ASCII : PH_BINARY;
                    end else begin
                        d_phase = PH_RANGE;
                        d_consumed = 1'b0;
                    end
                end else begin
                    d_stat = 1'b1;
                    d_code = ST_SIZE;
                    d_phase = PH_DONE;
                end
            end
            PH_RANGE: begin
                if (rng_ok) begin
                    d_rng = rng_v;
                    d_col = 15'd0;
                    d_row = 15'd0;
                    d_ci = 2'd0;
                    d_phase = (r_ft <= 3'd3) ? PH_ASCII : PH_BINARY;
                end else begin
                    d_stat = 1'b1;
                    d_code = ST_RANGE;
                    d_phase = PH_DONE;
                end
            end
            PH_ASCII: begin
                d_consumed = 1'b0;
                if ((r_ft == 3'd3) && (r_ci == 2'd0)) begin
                    d_hr = r_q;
                    d_ci = 2'd1;
                end else if ((r_ft == 3'd3) && (r_ci == 2'd1)) begin
                    d_hg = r_q;
                    d_ci = 2'd2;
                end else begin
                    d_gen = 1'b1;
                    if (r_ft == 3'd1) begin
                        d_res = mk_res(KIND_PIX, 15'd0, 15'd0, chan,
                                       (r_acc != 31'd0) ? 8'd0 : 8'd255, 8'd0, 8'd0, ST_OK);
                    end else if (r_ft == 3'd2) begin
                        d_res = mk_res(KIND_PIX, 15'd0, 15'd0, chan, r_q, 8'd0, 8'd0, ST_OK);
                    end else begin
                        d_ci = 2'd0;
                        d_res = mk_res(KIND_PIX, 15'd0, 15'd0, chan, r_hr, r_hg, r_q, ST_OK);
                    end
                    d_col = px_col;
                    d_row = px_row;
                    if (px_done) begin
                        d_stat = 1'b1;
                        d_code = ST_OK;
                        d_phase = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    logic    gen;
    t_result g;

    always_comb begin
        logic       fin;
        logic [3:0] ph_now;
        logic       qb;
        fin = 1'b0;
        ph_now = r_phase;
        qb = 1'b0;
        n_byte = r_byte;  n_eof = r_eof;  n_phase = r_phase;  n_ft = r_ft;
        n_acc = r_acc;  n_na = r_na;  n_cmt = r_cmt;  n_w = r_w;  n_h = r_h;
        n_rng = r_rng;  n_col = r_col;  n_row = r_row;  n_ci = r_ci;
        n_hr = r_hr;  n_hg = r_hg;  n_rem = r_rem;  n_lo = r_lo;  n_q = r_q;
        n_dcnt = r_dcnt;  n_bits = r_bits;  n_bsh = r_bsh;
        n_sp = r_sp;  n_scode = r_scode;
        gen = 1'b0;
        g = mk_res(KIND_STAT, 15'd0, 15'd0, chan, 8'd0, 8'd0, 8'd0, r_scode);
        case (i_cmd)
            CMD_LOAD: begin
                n_byte = i_byte;
                n_eof = i_eof;
            end
            CMD_DIV_START: begin
                n_rem = {1'b0, dvd[15:8]};
                n_lo = dvd[7:0];
                n_q = 8'd0;
                n_dcnt = 3'd0;
            end
            CMD_DIV_STEP: begin
                if (div_t >= {1'b0, r_rng}) begin
                    n_rem = div_t - {1'b0, r_rng};
                    qb = 1'b1;
                end else begin
                    n_rem = div_t;
                end
                n_lo = {r_lo[6:0], 1'b0};
                n_q = {r_q[6:0], qb};
                n_dcnt = r_dcnt + 3'd1;
            end
            CMD_EXEC: begin
                case (r_phase)
                    PH_MAGIC_P: begin
                        if (r_byte == 8'd80) begin
                            n_phase = PH_MAGIC_TYPE;
                        end else begin
                            n_sp = 1'b1;
                            n_scode = fail_code(r_phase);
                            n_phase = PH_DONE;
                        end
                    end
                    PH_MAGIC_TYPE: begin
                        if ((r_byte >= 8'd49) && (r_byte <= 8'd55)) begin
                            n_ft = r_byte[2:0];
                            n_phase = PH_MAGIC_SPACE;
                        end else begin
                            n_sp = 1'b1;
                            n_scode = fail_code(r_phase);
                            n_phase = PH_DONE;
                        end
                    end
                    PH_MAGIC_SPACE: begin
                        if (spc) begin
                            n_phase = (r_ft == 3'd7) ? PH_EXTRA : PH_WIDTH;
                        end else begin
                            n_sp = 1'b1;
                            n_scode = fail_code(r_phase);
                            n_phase = PH_DONE;
                        end
                    end
                    PH_EXTRA, PH_WIDTH, PH_HEIGHT, PH_RANGE, PH_ASCII: begin
                        if (r_na) begin
                            if (dig) begin
                                fin = 1'b1;
                                if (r_acc > ACC_LIMIT) begin
                                    n_na = 1'b0;
                                    n_sp = 1'b1;
                                    n_scode = fail_code(r_phase);
                                    n_phase = PH_DONE;
                                end else begin
                                    n_acc = acc_x10[30:0] + {27'd0, r_byte[3:0]};
                                end
                            end else begin
                                n_na = 1'b0;
                                n_phase = d_phase;  n_w = d_w;  n_h = d_h;  n_rng = d_rng;
                                n_col = d_col;  n_row = d_row;  n_ci = d_ci;
                                n_hr = d_hr;  n_hg = d_hg;
                                gen = d_gen;
                                g = d_res;
                                if (d_stat) begin
                                    n_sp = 1'b1;
                                    n_scode = d_code;
                                end
                                ph_now = d_phase;
                                fin = d_consumed || (d_phase == PH_DONE);
                            end
                        end
                        if (!fin) begin
                            if (r_cmt) begin
                                if (r_byte == 8'd10) begin
                                    n_cmt = 1'b0;
                                end
                            end else if (spc) begin
                                n_cmt = r_cmt;
                            end else if (r_byte == 8'd35) begin
                                n_cmt = 1'b1;
                            end else if (dig) begin
                                n_na = 1'b1;
                                n_acc = {27'd0, r_byte[3:0]};
                            end else begin
                                n_sp = 1'b1;
                                n_scode = fail_code(ph_now);
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    PH_BINARY: begin
                        if (r_ft == 3'd4) begin
                            n_bits = (bits_rem > 15'd8) ? 4'd8 : bits_rem[3:0];
                            n_bsh = r_byte;
                        end else if ((r_ft == 3'd6) && (r_ci == 2'd0)) begin
                            n_hr = r_q;
                            n_ci = 2'd1;
                        end else if ((r_ft == 3'd6) && (r_ci == 2'd1)) begin
                            n_hg = r_q;
                            n_ci = 2'd2;
                        end else begin
                            gen = 1'b1;
                            if (r_ft == 3'd5) begin
                                g = mk_res(KIND_PIX, 15'd0, 15'd0, chan, r_q, 8'd0, 8'd0, ST_OK);
                            end else if (r_ft == 3'd6) begin
                                n_ci = 2'd0;
                                g = mk_res(KIND_PIX, 15'd0, 15'd0, chan, r_hr, r_hg, r_q, ST_OK);
                            end else begin
                                g = mk_res(KIND_PIX, 15'd0, 15'd0, chan, scale7(r_byte[7:5]),
                                           scale7(r_byte[4:2]), scale3(r_byte[1:0]), ST_OK);
                            end
                            n_col = px_col;
                            n_row = px_row;
                            if (px_done) begin
                                n_sp = 1'b1;
                                n_scode = ST_OK;
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_BIT: begin
                gen = 1'b1;
                g = mk_res(KIND_PIX, 15'd0, 15'd0, 2'd1, r_bsh[7] ? 8'd0 : 8'd255,
                           8'd0, 8'd0, ST_OK);
                n_bsh = {r_bsh[6:0], 1'b0};
                n_bits = r_bits - 4'd1;
                if (r_bits == 4'd1) begin
                    n_col = px_col;
                    n_row = px_row;
                    if (px_done) begin
                        n_sp = 1'b1;
                        n_scode = ST_OK;
                        n_phase = PH_DONE;
                    end
                end else begin
                    n_col = col_inc[14:0];
                end
            end
            CMD_STAT: begin
                gen = 1'b1;
                n_sp = 1'b0;
            end
            CMD_EDELIV: begin
                if ((r_phase inside {[PH_EXTRA:PH_ASCII]}) && r_na) begin
                    n_na = 1'b0;
                    n_phase = d_phase;  n_w = d_w;  n_h = d_h;  n_rng = d_rng;
                    n_col = d_col;  n_row = d_row;  n_ci = d_ci;
                    n_hr = d_hr;  n_hg = d_hg;
                    gen = d_gen;
                    g = d_res;
                    ph_now = d_phase;
                    if (d_stat) begin
                        n_sp = 1'b1;
                        n_scode = d_code;
                    end
                end
                if (ph_now != PH_DONE) begin
                    n_sp = 1'b1;
                    n_scode = fail_code(ph_now);
                    n_phase = PH_DONE;
                end
            end
            CMD_ERESET: begin
                n_phase = PH_MAGIC_P;  n_ft = 3'd0;  n_acc = 31'd0;  n_na = 1'b0;
                n_cmt = 1'b0;  n_w = 15'd0;  n_h = 15'd0;  n_rng = 8'd1;
                n_col = 15'd0;  n_row = 15'd0;  n_ci = 2'd0;  n_hr = 8'd0;  n_hg = 8'd0;
            end
            default: begin
            end
        endcase

        // Two-entry result queue: the newest result waits in the pending slot
        // until it is known whether another result of the same byte follows.
        n_out = r_out;
        n_out_v = r_out_v && !i_out_ready;
        n_pend = r_pend;
        n_pend_v = r_pend_v;
        if (gen) begin
            if (r_pend_v) begin
                n_out = r_pend;
                n_out.last = 1'b0;
                n_out_v = 1'b1;
            end
            n_pend = g;
            n_pend_v = 1'b1;
        end
        if ((i_cmd == CMD_FLUSH) && r_pend_v) begin
            n_out = r_pend;
            n_out.last = 1'b1;
            n_out_v = 1'b1;
            n_pend_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC_P;  r_ft <= 3'd0;  r_acc <= 31'd0;  r_na <= 1'b0;
            r_cmt <= 1'b0;  r_w <= 15'd0;  r_h <= 15'd0;  r_rng <= 8'd1;
            r_col <= 15'd0;  r_row <= 15'd0;  r_ci <= 2'd0;  r_hr <= 8'd0;  r_hg <= 8'd0;
            r_eof <= 1'b0;  r_dcnt <= 3'd0;  r_bits <= 4'd0;
            r_sp <= 1'b0;  r_scode <= ST_OK;
            r_pend_v <= 1'b0;  r_out_v <= 1'b0;
        end else begin
            r_phase <= n_phase;  r_ft <= n_ft;  r_acc <= n_acc;  r_na <= n_na;
            r_cmt <= n_cmt;  r_w <= n_w;  r_h <= n_h;  r_rng <= n_rng;
            r_col <= n_col;  r_row <= n_row;  r_ci <= n_ci;  r_hr <= n_hr;  r_hg <= n_hg;
            r_eof <= n_eof;  r_dcnt <= n_dcnt;  r_bits <= n_bits;
            r_sp <= n_sp;  r_scode <= n_scode;
            r_pend_v <= n_pend_v;  r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_rem <= n_rem;
        r_lo <= n_lo;
        r_q <= n_q;
        r_bsh <= n_bsh;
        r_pend <= n_pend;
        r_out <= n_out;
    end

    assign o_status.need_div_byte =
        ((r_phase == PH_BINARY) && ((r_ft == 3'd5) || (r_ft == 3'd6))) ||
        ((r_phase == PH_ASCII) && r_na && !dig && ((r_ft == 3'd2) || (r_ft == 3'd3)));
    assign o_status.need_div_eof =
        (r_phase == PH_ASCII) && r_na && ((r_ft == 3'd2) || (r_ft == 3'd3));
    assign o_status.div_last  = (r_dcnt == 3'd7);
    assign o_status.bits_nz   = (r_bits != 4'd0);
    assign o_status.stat_pend = r_sp;
    assign o_status.eof       = r_eof;
    assign o_status.slot_free = !r_out_v || i_out_ready;

    assign o_result       = r_out;
    assign o_result_valid = r_out_v;

endmodule

// ----- rtl/core/pnmd_ctrl.sv -----
// Sequencing state machine of the PNM stream decoder.
// Issues datapath commands from datapath status; depends on pnmd_pkg.
module pnmd_ctrl import pnmd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PRE    = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_EXEC   = 4'd3;
    localparam logic [3:0] S_POST   = 4'd4;
    localparam logic [3:0] S_BITS   = 4'd5;
    localparam logic [3:0] S_STAT   = 4'd6;
    localparam logic [3:0] S_EOFCHK = 4'd7;
    localparam logic [3:0] S_EEXEC  = 4'd8;
    localparam logic [3:0] S_EPOST  = 4'd9;
    localparam logic [3:0] S_ERST   = 4'd10;
    localparam logic [3:0] S_FLUSH  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_eofpass, n_eofpass;

    always_comb begin
        n_state = r_state;
        n_eofpass = r_eofpass;
        o_cmd = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = CMD_LOAD;
                    n_eofpass = 1'b0;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (i_status.need_div_byte) begin
                    o_cmd = CMD_DIV_START;
                    n_state = S_DIV;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_DIV: begin
                o_cmd = CMD_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = r_eofpass ? S_EEXEC : S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.slot_free) begin
                    o_cmd = CMD_EXEC;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (i_status.bits_nz) begin
                    n_state = S_BITS;
                end else if (i_status.stat_pend) begin
                    n_state = S_STAT;
                end else begin
                    n_state = S_EOFCHK;
                end
            end
            S_BITS: begin
                if (i_status.slot_free) begin
                    o_cmd = CMD_BIT;
                    n_state = S_POST;
                end
            end
            S_STAT: begin
                if (i_status.slot_free) begin
                    o_cmd = CMD_STAT;
                    n_state = r_eofpass ? S_ERST : S_EOFCHK;
                end
            end
            S_EOFCHK: begin
                if (!i_status.eof) begin
                    n_state = S_FLUSH;
                end else begin
                    n_eofpass = 1'b1;
                    if (i_status.need_div_eof) begin
                        o_cmd = CMD_DIV_START;
                        n_state = S_DIV;
                    end else begin
                        n_state = S_EEXEC;
                    end
                end
            end
            S_EEXEC: begin
                if (i_status.slot_free) begin
                    o_cmd = CMD_EDELIV;
                    n_state = S_EPOST;
                end
            end
            S_EPOST: begin
                n_state = i_status.stat_pend ? S_STAT : S_ERST;
            end
            S_ERST: begin
                o_cmd = CMD_ERESET;
                n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (i_status.slot_free) begin
                    o_cmd = CMD_FLUSH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eofpass <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eofpass <= n_eofpass;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- rtl/core/pnm_image_stream_decoder_top.sv -----
// The block works on one byte at a time; the next byte transfers only after the current one is done.
// Reset: synchronous, active low; the parser returns to the first magic byte, the queue empties.
// Top level of the PNM stream decoder; depends on pnmd_pkg, both channel
// interfaces, pnmd_datapath and pnmd_ctrl.
module pnm_image_stream_decoder_top import pnmd_pkg::*; #(
    parameter int P_MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pnmd_in_if.sink   i_in,
    pnmd_out_if.source o_out
);

    // The controller walks each byte through load, optional divide, execute,
    // bitmap unpacking, status, end-of-file handling and a final flush that
    // marks the last result of the byte. The datapath keeps the newest result
    // in a pending slot so that last_of_run can be set once the byte is done;
    // the output register lets the next byte transfer while a result waits.
    t_cmd       cmd;
    t_dp_status status;
    t_result    result;
    logic       result_valid;

    pnmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pnmd_datapath #(
        .P_MAX_SIDE (P_MAX_SIDE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_byte         (i_in.data_byte),
        .i_eof          (i_in.end_of_file),
        .i_out_ready    (o_out.ready),
        .o_status       (status),
        .o_result       (result),
        .o_result_valid (result_valid)
    );

    // Result fields go straight from the output register to the channel.
    assign o_out.valid        = result_valid;
    assign o_out.result_kind  = result.kind;
    assign o_out.image_width  = result.width;
    assign o_out.image_height = result.height;
    assign o_out.channels     = result.chans;
    assign o_out.gray_or_red  = result.red;
    assign o_out.green_value  = result.green;
    assign o_out.blue_value   = result.blue;
    assign o_out.status_code  = result.code;
    assign o_out.last_of_run  = result.last;

`ifndef NO_ASSERTIONS
    // Any command that may push a result only issues when the output slot is free.
    a_push_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == CMD_EXEC || cmd == CMD_BIT || cmd == CMD_STAT || cmd == CMD_EDELIV ||
         cmd == CMD_FLUSH) |-> status.slot_free)
        else $error("result pushed while output register is blocked");

    // No status result is left over when a new byte may transfer.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !status.stat_pend)
        else $error("status pending while accepting a byte");

    // One byte at a time: a transfer is never followed directly by another.
    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted twice in a row");
`endif

endmodule
